>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

>>> hdl/wmbr_pkg.sv
package wmbr_pkg;

    // Pixel count and reflectance widths.
    localparam int COUNT_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int REFL_BITS  = 32;
    localparam int PROD_BITS  = FIELD_BITS + REFL_BITS;

    // Divider geometry: one restoring step per quotient bit.
    localparam int DIV_BITS       = 32;
    localparam int DIV_STEPS      = 4;
    localparam int DIV_STAGES     = DIV_BITS / DIV_STEPS;

    // eps = 0.0001 in Q2.30, and 2^46 seen through the top of a 32-bit quotient.
    localparam logic [DIV_BITS:0] EPS_Q30      = 33'd107374;
    localparam logic [DIV_BITS:0] RECIP_REM0   = 33'd16384;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_GAIN2  = 3'd1,
        REG_GAIN4  = 3'd2,
        REG_GAIN5  = 3'd3,
        REG_GAIN6  = 3'd4,
        REG_THRESH = 3'd5,
        REG_SLOPE  = 3'd6,
        REG_OFFSET = 3'd7
    } cfg_reg_t;

    // Index modes.
    localparam logic MODE_RECIP = 1'b0;
    localparam logic MODE_RATIO = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic [REFL_BITS-1:0]        gain2;
        logic [REFL_BITS-1:0]        gain4;
        logic [REFL_BITS-1:0]        gain5;
        logic [REFL_BITS-1:0]        gain6;
        logic signed [15:0]          thresh;
        logic signed [31:0]          slope;
        logic signed [31:0]          offset;
    } cfg_t;

    // Operands of one long division: upper remainder, low dividend word, divisor.
    typedef struct packed {
        logic [DIV_BITS:0]   rem;
        logic [DIV_BITS-1:0] low;
        logic [DIV_BITS:0]   dvs;
    } div_in_t;

    // Per-pixel flags that travel beside the dividers.
    typedef struct packed {
        logic [REFL_BITS-1:0] r6;
        logic                 nneg;
        logic                 den_zero;
        logic                 r2_zero;
        logic                 ratio_sat;
        logic                 sat;
    } side_t;

    typedef struct packed {
        logic        water;
        logic [31:0] index;
        logic        sat;
    } res_t;

endpackage

>>> hdl/wmbr_divider.sv
module wmbr_divider (
    input  logic                            clk,
    input  logic                            en,
    input  wmbr_pkg::div_in_t               din,
    output logic [wmbr_pkg::DIV_BITS-1:0]   quo
);
    import wmbr_pkg::*;

    logic [DIV_BITS:0]   rem_reg [DIV_STAGES];
    logic [DIV_BITS-1:0] low_reg [DIV_STAGES];
    logic [DIV_BITS:0]   dvs_reg [DIV_STAGES];
    logic [DIV_BITS-1:0] quo_reg [DIV_STAGES];

    // Each stage retires DIV_STEPS quotient bits by restoring division.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [DIV_BITS:0]   rem_in;
        logic [DIV_BITS-1:0] low_in;
        logic [DIV_BITS:0]   dvs_in;
        logic [DIV_BITS-1:0] quo_in;
        logic [DIV_BITS:0]   rem_next;
        logic [DIV_BITS-1:0] low_next;
        logic [DIV_BITS-1:0] quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = din.rem;
            assign low_in = din.low;
            assign dvs_in = din.dvs;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign dvs_in = dvs_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        always_comb
        begin : steps
            logic [DIV_BITS+1:0] trial;
            rem_next = rem_in;
            low_next = low_in;
            quo_next = quo_in;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                trial    = {rem_next, low_next[DIV_BITS-1]};
                low_next = {low_next[DIV_BITS-2:0], 1'b0};
                if (trial >= {1'b0, dvs_in})
                begin
                    rem_next = (DIV_BITS+1)'(trial - {1'b0, dvs_in});
                    quo_next = {quo_next[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DIV_BITS:0];
                    quo_next = {quo_next[DIV_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                low_reg[g] <= low_next;
                dvs_reg[g] <= dvs_in;
                quo_reg[g] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

>>> hdl/wmbr_front.sv
module wmbr_front (
    input  logic                              clk,
    input  logic                              en,
    input  wmbr_pkg::cfg_t                    cfg,
    input  logic [wmbr_pkg::FIELD_BITS-1:0]   band2_count,
    input  logic [wmbr_pkg::FIELD_BITS-1:0]   band4_count,
    input  logic [wmbr_pkg::FIELD_BITS-1:0]   band5_count,
    input  logic [wmbr_pkg::FIELD_BITS-1:0]   band6_count,
    output wmbr_pkg::div_in_t                 div_ndwi,
    output wmbr_pkg::div_in_t                 div_a,
    output wmbr_pkg::div_in_t                 div_b,
    output wmbr_pkg::side_t                   side
);
    import wmbr_pkg::*;

    logic [PROD_BITS-1:0] p2_reg, p4_reg, p5_reg, p6_reg;
    logic [REFL_BITS-1:0] r2, r4, r5, r6;
    logic                 s2, s4, s5, s6;
    logic [REFL_BITS:0]   den;
    logic [REFL_BITS-1:0] nmag;
    logic                 nneg;
    div_in_t              ndwi_next, a_next, b_next;
    side_t                side_next;
    div_in_t              ndwi_reg, a_reg, b_reg;
    side_t                side_reg;

    function automatic logic [PROD_BITS-1:0] scale(
        input logic [FIELD_BITS-1:0] cnt,
        input logic [REFL_BITS-1:0]  gain
    );
        logic [PROD_BITS-1:0] c;
        c = PROD_BITS'(cnt[COUNT_BITS-1:0]);
        return PROD_BITS'(c * PROD_BITS'(gain));
    endfunction

    // Stage one: raw count times gain.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg <= scale(band2_count, cfg.gain2);
            p4_reg <= scale(band4_count, cfg.gain4);
            p5_reg <= scale(band5_count, cfg.gain5);
            p6_reg <= scale(band6_count, cfg.gain6);
        end
    end

    // Drop two fraction bits and clamp to Q2.30.
    assign s2 = |p2_reg[PROD_BITS-1:REFL_BITS+2];
    assign s4 = |p4_reg[PROD_BITS-1:REFL_BITS+2];
    assign s5 = |p5_reg[PROD_BITS-1:REFL_BITS+2];
    assign s6 = |p6_reg[PROD_BITS-1:REFL_BITS+2];
    assign r2 = s2 ? '1 : p2_reg[REFL_BITS+1:2];
    assign r4 = s4 ? '1 : p4_reg[REFL_BITS+1:2];
    assign r5 = s5 ? '1 : p5_reg[REFL_BITS+1:2];
    assign r6 = s6 ? '1 : p6_reg[REFL_BITS+1:2];

    // Normalized difference operands.
    assign den  = {1'b0, r6} + {1'b0, r2};
    assign nneg = r6 < r2;
    assign nmag = nneg ? r2 - r6 : r6 - r2;

    // Divider operands; divider A is the band 4 reciprocal or the band ratio.
    always_comb
    begin
        ndwi_next.rem = (DIV_BITS+1)'(nmag[REFL_BITS-1:17]);
        ndwi_next.low = {nmag[16:0], 15'b0};
        ndwi_next.dvs = den;

        if (cfg.mode == MODE_RATIO)
        begin
            a_next.rem = (DIV_BITS+1)'(r6[REFL_BITS-1:16]);
            a_next.low = {r6[15:0], 16'b0};
            a_next.dvs = {1'b0, r2};
        end
        else
        begin
            a_next.rem = RECIP_REM0;
            a_next.low = '0;
            a_next.dvs = {1'b0, r4} + EPS_Q30;
        end

        b_next.rem = RECIP_REM0;
        b_next.low = '0;
        b_next.dvs = {1'b0, r5} + EPS_Q30;

        side_next.r6        = r6;
        side_next.nneg      = nneg;
        side_next.den_zero  = (den == '0);
        side_next.r2_zero   = (r2 == '0);
        side_next.ratio_sat = (r2 != '0) && ({16'b0, r6[REFL_BITS-1:16]} >= r2);
        side_next.sat       = s2 | s4 | s5 | s6;
    end

    // Stage two register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ndwi_reg <= ndwi_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            side_reg <= side_next;
        end
    end

    assign div_ndwi = ndwi_reg;
    assign div_a    = a_reg;
    assign div_b    = b_reg;
    assign side     = side_reg;

endmodule

>>> hdl/wmbr_back.sv
module wmbr_back (
    input  logic                            clk,
    input  logic                            en,
    input  wmbr_pkg::cfg_t                  cfg,
    input  wmbr_pkg::side_t                 side,
    input  logic [wmbr_pkg::DIV_BITS-1:0]   q_ndwi,
    input  logic [wmbr_pkg::DIV_BITS-1:0]   q_a,
    input  logic [wmbr_pkg::DIV_BITS-1:0]   q_b,
    output wmbr_pkg::res_t                  res
);
    import wmbr_pkg::*;

    logic [16:0]          ndwi_mag;
    logic signed [17:0]   ndwi;
    logic signed [17:0]   thresh;
    logic                 ineg;
    logic [31:0]          diff;
    logic [31:0]          ratio;

    logic                 water1_reg, ineg1_reg, sat1_reg;
    logic [31:0]          opnd1_reg;
    logic [REFL_BITS-1:0] r6_1_reg;

    logic                 water2_reg, ineg2_reg, sat2_reg;
    logic [63:0]          prod0_reg;
    logic [31:0]          ratio2_reg;

    logic [31:0]          imag;
    logic                 kneg;
    logic [31:0]          kmag;
    logic                 water3_reg, neg3_reg, sat3_reg;
    logic [63:0]          prod1_reg;

    logic [47:0]          pmag;
    logic signed [49:0]   prod;
    logic signed [49:0]   sum;
    logic                 ovf;

    // Water test and index operand selection.
    assign ndwi_mag = side.den_zero ? '0 : q_ndwi[16:0];
    assign ndwi     = side.nneg ? -$signed({1'b0, ndwi_mag}) : $signed({1'b0, ndwi_mag});
    assign thresh   = $signed({{2{cfg.thresh[15]}}, cfg.thresh});
    assign ineg     = (cfg.mode == MODE_RECIP) && (q_a < q_b);
    assign diff     = (q_a < q_b) ? q_b - q_a : q_a - q_b;
    assign ratio    = side.ratio_sat ? '1 : (side.r2_zero ? '0 : q_a);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            water1_reg <= (ndwi <= thresh);
            ineg1_reg  <= ineg;
            sat1_reg   <= side.sat | ((cfg.mode == MODE_RATIO) && side.ratio_sat);
            opnd1_reg  <= (cfg.mode == MODE_RATIO) ? ratio : diff;
            r6_1_reg   <= side.r6;
        end
    end

    // Reciprocal difference times band 6.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            water2_reg <= water1_reg;
            ineg2_reg  <= ineg1_reg;
            sat2_reg   <= sat1_reg;
            prod0_reg  <= 64'(opnd1_reg) * 64'(r6_1_reg);
            ratio2_reg <= opnd1_reg;
        end
    end

    // Index times slope magnitude.
    assign imag = (cfg.mode == MODE_RATIO) ? ratio2_reg : prod0_reg[61:30];
    assign kneg = cfg.slope[31];
    assign kmag = kneg ? 32'(-cfg.slope) : 32'(cfg.slope);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            water3_reg <= water2_reg;
            neg3_reg   <= ineg2_reg ^ kneg;
            sat3_reg   <= sat2_reg;
            prod1_reg  <= 64'(imag) * 64'(kmag);
        end
    end

    // Signed product plus offset, clamped to 32 bits.
    assign pmag = prod1_reg[63:16];
    assign prod = neg3_reg ? -$signed({2'b0, pmag}) : $signed({2'b0, pmag});
    assign sum  = prod + $signed({{18{cfg.offset[31]}}, cfg.offset});
    assign ovf  = (sum[49:31] != '0) && (sum[49:31] != '1);

    always_comb
    begin
        res.water = water3_reg;
        if (!water3_reg)
        begin
            res.index = '0;
            res.sat   = 1'b0;
        end
        else if (ovf)
        begin
            res.index = sum[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            res.sat   = 1'b1;
        end
        else
        begin
            res.index = sum[31:0];
            res.sat   = sat3_reg;
        end
    end

endmodule

>>> hdl/water_mask_band_ratio_index_unit.sv
// Water mask and band-ratio index, one pixel per clock. Each input word carries
// four band counts; each result word carries the Q15.16 index in tdata and the
// water and saturation flags in tuser. A word passes two front stages (gain multiply,
// clamp and operand setup), eight divider stages of four restoring steps each, three
// back stages (water test, reciprocal product, slope product) and the output
// register. Throughput is one word per clock, set by the fully pipelined dividers;
// the whole pipe holds while the output word is waiting. Configuration must be
// written only while the pipe is empty; the block itself does not enforce this.
`include "assert_macros.svh"

module water_mask_band_ratio_index_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // band2_count [15:0], band4_count [31:16], band5_count [47:32], band6_count [63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // index_value [31:0]
    output logic [31:0] m_axis_tdata,
    // is_water [0], saturated [1]
    output logic [1:0]  m_axis_tuser
);
    import wmbr_pkg::*;

    localparam int LAT = 2 + DIV_STAGES + 3;

    cfg_t                cfg_reg;
    logic                adv;
    logic [LAT-1:0]      vld_reg;
    logic                out_valid_reg;
    res_t                out_reg;
    div_in_t             div_ndwi, div_a, div_b;
    side_t               side;
    side_t               side_reg [DIV_STAGES];
    logic [DIV_BITS-1:0] q_ndwi, q_a, q_b;
    res_t                res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: MODE_RECIP, gain2: '0, gain4: '0, gain5: '0, gain6: '0,
                         thresh: '0, slope: 32'sd65536, offset: '0};
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE:   cfg_reg.mode   <= cfg_wdata[0];
                REG_GAIN2:  cfg_reg.gain2  <= cfg_wdata;
                REG_GAIN4:  cfg_reg.gain4  <= cfg_wdata;
                REG_GAIN5:  cfg_reg.gain5  <= cfg_wdata;
                REG_GAIN6:  cfg_reg.gain6  <= cfg_wdata;
                REG_THRESH: cfg_reg.thresh <= cfg_wdata[15:0];
                REG_SLOPE:  cfg_reg.slope  <= cfg_wdata;
                REG_OFFSET: cfg_reg.offset <= cfg_wdata;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // The pipe moves whenever the output register is free or being drained.
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    wmbr_front u_front (
        .clk         (clk),
        .en          (adv),
        .cfg         (cfg_reg),
        .band2_count (s_axis_tdata[15:0]),
        .band4_count (s_axis_tdata[31:16]),
        .band5_count (s_axis_tdata[47:32]),
        .band6_count (s_axis_tdata[63:48]),
        .div_ndwi    (div_ndwi),
        .div_a       (div_a),
        .div_b       (div_b),
        .side        (side)
    );

    wmbr_divider u_div_ndwi (.clk(clk), .en(adv), .din(div_ndwi), .quo(q_ndwi));
    wmbr_divider u_div_a    (.clk(clk), .en(adv), .din(div_a),    .quo(q_a));
    wmbr_divider u_div_b    (.clk(clk), .en(adv), .din(div_b),    .quo(q_b));

    // Flags delayed to line up with the divider results.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    wmbr_back u_back (
        .clk    (clk),
        .en     (adv),
        .cfg    (cfg_reg),
        .side   (side_reg[DIV_STAGES-1]),
        .q_ndwi (q_ndwi),
        .q_a    (q_a),
        .q_b    (q_b),
        .res    (res)
    );

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], s_axis_tvalid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_reg.index;
    assign m_axis_tuser[0] = out_reg.water;
    assign m_axis_tuser[1] = out_reg.sat;

    `ASSERT_CLK(a_not_water_clear, clk, rst_n,
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    `ASSERT_CLK(a_accept_enters, clk, rst_n,
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
    `ASSERT_NEVER(a_stall_blocks_input, clk, rst_n,
        m_axis_tvalid && !m_axis_tready && s_axis_tready)
    `ASSERT_CLK(a_last_stage_drains, clk, rst_n,
        (vld_reg[LAT-1] && s_axis_tready) |=> m_axis_tvalid)

endmodule

>>> tb/tb_water_mask_band_ratio_index_unit.sv
`timescale 1ns / 1ps

module tb_water_mask_band_ratio_index_unit;
    import wmbr_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_PIXELS  = 100;
    localparam int NUM_PHASES    = 12;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    water_mask_band_ratio_index_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // One directed pixel: four band counts and, where known, the result.
    typedef struct {
        logic [15:0] b2;
        logic [15:0] b4;
        logic [15:0] b5;
        logic [15:0] b6;
        res_t        known;
    } pixel_row_t;

    cfg_t        shadow_cfg;
    res_t        pending_pixels[$];
    int          error_count;
    int          pixels_sent;
    int          results_seen;
    int          water_seen;
    int          clamp_seen;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    // Clock.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Count to reflectance in Q2.30, clamping at the 32-bit maximum.
    function automatic logic [63:0] reflectance(input logic [15:0] cnt,
                                                input logic [31:0] gain,
                                                inout bit clamp);
        logic [63:0] r;
        r = (64'(cnt) * 64'(gain)) >> 2;
        if (r > 64'hFFFF_FFFF)
        begin
            clamp = 1'b1;
            r = 64'hFFFF_FFFF;
        end
        return r;
    endfunction

    // Expected result word for one pixel under the given register set.
    function automatic res_t predict_pixel(input logic [15:0] c2, input logic [15:0] c4,
                                           input logic [15:0] c5, input logic [15:0] c6,
                                           input cfg_t c);
        logic [63:0] r2, r4, r5, r6, den, nmag, rc4, rc5, dif, imag, kmag, pmag;
        longint      ndwi, prod, total;
        bit          clamp, ineg, kneg;
        res_t        o;
        clamp = 1'b0;
        r2 = reflectance(c2, c.gain2, clamp);
        r4 = reflectance(c4, c.gain4, clamp);
        r5 = reflectance(c5, c.gain5, clamp);
        r6 = reflectance(c6, c.gain6, clamp);
        den = r6 + r2;
        ndwi = 0;
        if (den != 0)
        begin
            nmag = (r6 < r2) ? r2 - r6 : r6 - r2;
            ndwi = longint'((nmag << 15) / den);
            if (r6 < r2)
                ndwi = -ndwi;
        end
        o = '0;
        if (ndwi > longint'(c.thresh))
            return o;
        if (c.mode == MODE_RECIP)
        begin
            rc4 = (64'd1 << 46) / (r4 + 64'(EPS_Q30));
            rc5 = (64'd1 << 46) / (r5 + 64'(EPS_Q30));
            ineg = rc4 < rc5;
            dif = ineg ? rc5 - rc4 : rc4 - rc5;
            imag = (dif * r6) >> 30;
        end
        else
        begin
            ineg = 1'b0;
            imag = 0;
            if (r2 != 0)
            begin
                imag = (r6 << 16) / r2;
                if (imag > 64'hFFFF_FFFF)
                begin
                    imag = 64'hFFFF_FFFF;
                    clamp = 1'b1;
                end
            end
        end
        kneg = c.slope < 0;
        kmag = kneg ? 64'(-longint'(c.slope)) : 64'(longint'(c.slope));
        pmag = (imag * kmag) >> 16;
        prod = (ineg != kneg) ? -longint'(pmag) : longint'(pmag);
        total = prod + longint'(c.offset);
        if (total > 64'sd2147483647)
        begin
            total = 64'sd2147483647;
            clamp = 1'b1;
        end
        else if (total < -64'sd2147483648)
        begin
            total = -64'sd2147483648;
            clamp = 1'b1;
        end
        o.water = 1'b1;
        o.index = total[31:0];
        o.sat   = clamp;
        return o;
    endfunction

    // Register write; the shadow copy follows at once since the pipe is empty.
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_MODE:   shadow_cfg.mode   = value[0];
            REG_GAIN2:  shadow_cfg.gain2  = value;
            REG_GAIN4:  shadow_cfg.gain4  = value;
            REG_GAIN5:  shadow_cfg.gain5  = value;
            REG_GAIN6:  shadow_cfg.gain6  = value;
            REG_THRESH: shadow_cfg.thresh = value[15:0];
            REG_SLOPE:  shadow_cfg.slope  = value;
            default:    shadow_cfg.offset = value;
        endcase
    endtask

    task automatic load_regs(input cfg_t c);
        write_reg(REG_MODE, {31'd0, c.mode});
        write_reg(REG_GAIN2, c.gain2);
        write_reg(REG_GAIN4, c.gain4);
        write_reg(REG_GAIN5, c.gain5);
        write_reg(REG_GAIN6, c.gain6);
        write_reg(REG_THRESH, {{16{c.thresh[15]}}, c.thresh});
        write_reg(REG_SLOPE, c.slope);
        write_reg(REG_OFFSET, c.offset);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stop offering words and wait for the pipe to drain before touching the registers.
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one pixel word, with a random gap first, and hold it until taken.
    // The task is entered at a rising edge, right after the previous handshake.
    task automatic send_pixel(input logic [15:0] c2, input logic [15:0] c4,
                              input logic [15:0] c5, input logic [15:0] c6,
                              input bit has_known, input res_t known);
        res_t want;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c6, c5, c4, c2};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = predict_pixel(c2, c4, c5, c6, shadow_cfg);
        if (has_known && want != known)
        begin
            $display("%0t: predictor disagrees on a directed pixel: expected %h actual %h",
                     $time, known, want);
            error_count++;
        end
        pending_pixels.push_back(has_known ? known : want);
        pixels_sent++;
    endtask

    function automatic logic [15:0] pick_count();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom >> $urandom_range(0, 20);
        endcase
    endfunction

    // Receiver: check each result word and stall at random.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result word: index %h user %b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_axis_tuser[0] !== want.water)
                begin
                    $display("%0t: is_water mismatch: expected %b actual %b",
                             $time, want.water, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tdata !== want.index)
                begin
                    $display("%0t: index_value mismatch: expected %h actual %h",
                             $time, want.index, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.sat)
                begin
                    $display("%0t: saturated mismatch: expected %b actual %b",
                             $time, want.sat, m_axis_tuser[1]);
                    error_count++;
                end
                water_seen += want.water;
                clamp_seen += want.sat;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("water_mask_band_ratio_index_unit regression: fail");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        pixel_row_t rows[8];
        cfg_t       c;
        res_t       reset_result;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_MODE;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        pixels_sent   = 0;
        results_seen  = 0;
        water_seen    = 0;
        clamp_seen    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 11;
        recv_idle_pct = 66;
        shadow_cfg    = '{mode: MODE_RECIP, gain2: '0, gain4: '0, gain5: '0, gain6: '0,
                          thresh: '0, slope: 32'sd65536, offset: '0};

        // With zero gains every reflectance is zero: water, index equals offset 0.
        reset_result = '{water: 1'b1, index: 32'd0, sat: 1'b0};
        rows[0] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, reset_result};
        rows[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, reset_result};
        rows[2] = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, reset_result};
        rows[3] = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, reset_result};
        rows[4] = '{16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF, reset_result};
        rows[5] = '{16'h0001, 16'h0001, 16'h0001, 16'h0001, reset_result};
        rows[6] = '{16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0, reset_result};
        rows[7] = '{16'h0100, 16'h0002, 16'h8000, 16'h0080, reset_result};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: reset registers, then a fixed set with full-scale band 2 and band 5 gains in both modes.
        foreach (rows[i])
            send_pixel(rows[i].b2, rows[i].b4, rows[i].b5, rows[i].b6, 1'b1, rows[i].known);
        for (int m = 0; m < 2; m++)
        begin
            drain_pipe();
            c = '{mode: m[0], gain2: 32'hFFFF_FFFF, gain4: 32'h0000_1000,
                  gain5: 32'hFFFF_FFFF, gain6: 32'h0010_0000,
                  thresh: 16'sh7FFF, slope: 32'sh7FFF_FFFF, offset: 32'sh7FFF_FFFF};
            load_regs(c);
            foreach (rows[i])
                send_pixel(rows[i].b2, rows[i].b4, rows[i].b5, rows[i].b6, 1'b0, reset_result);
        end

        // Random part: four register sets under each of three idling patterns.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p / 4)
                0:       begin send_idle_pct = 11; recv_idle_pct = 66; end
                1:       begin send_idle_pct = 66; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            drain_pipe();
            c.mode  = p[0];
            c.gain2 = pick_gain();
            c.gain4 = pick_gain();
            c.gain5 = pick_gain();
            c.gain6 = pick_gain();
            case (p % 4)
                0:
                begin
                    c.thresh = 16'sh7FFF;
                    c.slope  = 32'sh7FFF_FFFF;
                    c.offset = 32'sh7FFF_FFFF;
                end
                1:
                begin
                    c.thresh = -16'sh8000;
                    c.slope  = 32'sh8000_0000;
                    c.offset = 32'sh8000_0000;
                end
                default:
                begin
                    c.thresh = 16'($urandom);
                    c.slope  = $urandom >> $urandom_range(0, 16);
                    c.offset = $urandom;
                    if ($urandom_range(1))
                        c.slope = -c.slope;
                end
            endcase
            load_regs(c);
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel(pick_count(), pick_count(), pick_count(), pick_count(),
                           1'b0, reset_result);
        end

        drain_pipe();

        $display("Covered %0d pixels over %0d register sets and three idling patterns.",
                 pixels_sent, NUM_PHASES + 3);
        $display("Results checked: %0d, water %0d, clamped %0d.",
                 results_seen, water_seen, clamp_seen);
        if (error_count == 0 && pending_pixels.size() == 0)
            $display("water_mask_band_ratio_index_unit regression: pass");
        else
            $display("water_mask_band_ratio_index_unit regression: fail");
        $finish;
    end

endmodule
